@@ hw/rtl/epsimp_pkg.sv @@
// Shared types, widths and state codes for the edge polyline simplifier.
// No dependencies; imported by every module of the block.

package epsimp_pkg;

   localparam int COORD_BITS    = 16;
   localparam int FRAC_BITS_DEF = 4;
   localparam int LEN_W         = 24;
   localparam int THR_W         = 20;
   localparam int SUM_W         = 2 * COORD_BITS + 1;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(80);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [THR_W-1:0]      thr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CLOSE,
      ST_SEG_SQ,
      ST_SEG_ROOT,
      ST_CHORD_SQ,
      ST_CHORD_ROOT,
      ST_SUM,
      ST_TEST,
      ST_REPORT,
      ST_FINAL
   } state_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      keep;
      logic      edge_end;
      logic      last_of_run;
   } rsp_type;

endpackage

@@ hw/rtl/epsimp_sqsum.sv @@
// Squared distance front end: absolute differences, then dx*dx + dy*dy
// through one shared multiplier, dx first and then dy. Depends on epsimp_pkg.

module epsimp_sqsum (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  epsimp_pkg::coord_type          a_x,
   input  epsimp_pkg::coord_type          a_y,
   input  epsimp_pkg::coord_type          b_x,
   input  epsimp_pkg::coord_type          b_y,
   output logic                           done,
   output logic [epsimp_pkg::SUM_W-1:0]   sum
);
   import epsimp_pkg::*;

   coord_type dx_ff, dx_in, dy_ff, dy_in;
   coord_type mul_op;
   logic [2*COORD_BITS-1:0] sq;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic st1_ff, st2_ff, done_ff;

   always_comb begin
      dx_in = dx_ff;
      dy_in = dy_ff;
      if (start) begin
         dx_in = (a_x > b_x) ? (a_x - b_x) : (b_x - a_x);
         dy_in = (a_y > b_y) ? (a_y - b_y) : (b_y - a_y);
      end
      mul_op = st1_ff ? dx_ff : dy_ff;
      sq     = (2*COORD_BITS)'(mul_op) * (2*COORD_BITS)'(mul_op);
      acc_in = acc_ff;
      if (st1_ff) begin
         acc_in = SUM_W'(sq);
      end else if (st2_ff) begin
         acc_in = acc_ff + SUM_W'(sq);
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      acc_ff <= acc_in;
      if (reset) begin
         st1_ff  <= 1'b0;
         st2_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         st1_ff  <= start;
         st2_ff  <= st1_ff;
         done_ff <= st2_ff;
      end
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

@@ hw/rtl/epsimp_root.sv @@
// Digit-serial integer square root: two radicand bits per cycle, restoring,
// with FRAC_BITS fraction bits and saturation to the length width. Uses epsimp_pkg.

module epsimp_root #(
   parameter int FRAC_BITS = epsimp_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [epsimp_pkg::SUM_W-1:0]   radicand,
   output logic                           done,
   output epsimp_pkg::len_type            len
);
   import epsimp_pkg::*;

   localparam int ITER   = (SUM_W + 1) / 2 + FRAC_BITS;
   localparam int RAD_W  = 2 * ITER;
   localparam int REM_W  = ITER + 3;
   localparam int CNT_W  = $clog2(ITER + 1);
   localparam int ROOT_W = (ITER > LEN_W) ? ITER : LEN_W;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh, trial;
   logic [ITER-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [ROOT_W-1:0] root_ext;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = RAD_W'(radicand) << (2 * FRAC_BITS);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ITER);
      end else if (cnt_ff != '0) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ITER-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ITER-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign root_ext = ROOT_W'(root_ff);
   assign len      = (root_ext > ROOT_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                          : root_ext[LEN_W-1:0];
   assign done     = done_ff;

endmodule

@@ hw/rtl/epsimp_rspq.sv @@
// Two-entry result queue between the sequencer and the result channel.
// Depends on epsimp_pkg for the result beat type.

module epsimp_rspq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  epsimp_pkg::rsp_type push_data,
   output logic                push_ready,
   output logic                pop_valid,
   input  logic                pop_stall,
   output epsimp_pkg::rsp_type pop_data
);
   import epsimp_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;

   always_comb begin
      pop     = pop_valid && !pop_stall;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rptr_ff];

endmodule

@@ hw/rtl/edge_polyline_simplifier.sv @@
// Top level of the edge polyline simplifier: chain state, sequencer, threshold
// register. Depends on epsimp_pkg, epsimp_sqsum, epsimp_root and epsimp_rspq.
//
//   port group | direction | flow control  | beat
//   req_*      | in        | valid / stall | one edge point with chain marks
//   rsp_*      | out       | valid / stall | one point with keep and end flags
//   csr_*      | in        | valid / ready | deviation threshold write
//
// A point that opens a chain passes dispatch, then close if a chain was held, then final if
// it ends its chain. Any other point squares and roots two distances, the roots in the one
// serial root unit (two radicand bits a cycle), then sum, test, report, final at chain end.
// Synchronous reset clears the chain state and loads the threshold with 80.
// A stalled result waits in a two-entry queue; the sequencer holds only when full.

module edge_polyline_simplifier #(
   parameter int FRAC_BITS = epsimp_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  epsimp_pkg::coord_type req_point_x,
   input  epsimp_pkg::coord_type req_point_y,
   input  logic                  req_first_of_edge,
   input  logic                  req_last_of_edge,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output epsimp_pkg::coord_type rsp_out_x,
   output epsimp_pkg::coord_type rsp_out_y,
   output logic                  rsp_keep,
   output logic                  rsp_edge_end,
   output logic                  rsp_last_of_run,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  epsimp_pkg::thr_type   csr_deviation_threshold
);
   import epsimp_pkg::*;

   state_type state_ff, state_in;
   coord_type item_x_ff, item_x_in, item_y_ff, item_y_in;
   logic      item_first_ff, item_first_in, item_last_ff, item_last_in;
   coord_type anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   coord_type held_x_ff, held_x_in, held_y_ff, held_y_in;
   len_type   path_ff, path_in, seg_ff, seg_in, chord_ff, chord_in, sum_ff, sum_in;
   logic      held_valid_ff, held_valid_in, held_start_ff, held_start_in;
   logic      keep_ff, keep_in;
   thr_type   thr_ff, thr_in;

   logic       accept, start_branch;
   logic       sq_start, sq_done, root_done;
   coord_type  sq_a_x, sq_a_y;
   logic [SUM_W-1:0] sq_sum;
   len_type    root_len, diff;
   logic [LEN_W:0] path_wide;
   logic       push, push_ready;
   rsp_type    push_data, pop_data;

   assign accept       = req_valid && (state_ff == ST_IDLE);
   assign req_stall    = (state_ff != ST_IDLE);
   assign start_branch = item_first_ff || !held_valid_ff;
   assign csr_ready    = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (!start_branch) state_in = ST_SEG_SQ;
            else if (held_valid_ff) state_in = ST_CLOSE;
            else if (item_last_ff) state_in = ST_FINAL;
            else state_in = ST_IDLE;
         end
         ST_CLOSE: begin
            if (push_ready) state_in = item_last_ff ? ST_FINAL : ST_IDLE;
         end
         ST_SEG_SQ: begin
            if (sq_done) state_in = ST_SEG_ROOT;
         end
         ST_SEG_ROOT: begin
            if (root_done) state_in = ST_CHORD_SQ;
         end
         ST_CHORD_SQ: begin
            if (sq_done) state_in = ST_CHORD_ROOT;
         end
         ST_CHORD_ROOT: begin
            if (root_done) state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (push_ready) state_in = item_last_ff ? ST_FINAL : ST_IDLE;
         end
         ST_FINAL: begin
            if (push_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      sq_start  = 1'b0;
      sq_a_x    = anchor_x_ff;
      sq_a_y    = anchor_y_ff;
      push      = 1'b0;
      push_data = '0;
      unique case (state_ff)
         ST_DISPATCH: begin
            sq_start = !start_branch;
            sq_a_x   = held_x_ff;
            sq_a_y   = held_y_ff;
         end
         ST_SEG_ROOT: begin
            sq_start = root_done;
         end
         ST_CLOSE: begin
            push      = push_ready;
            push_data = '{x: held_x_ff, y: held_y_ff, keep: 1'b1, edge_end: 1'b1,
                          last_of_run: !item_last_ff};
         end
         ST_REPORT: begin
            push      = push_ready;
            push_data = '{x: held_x_ff, y: held_y_ff, keep: keep_ff, edge_end: 1'b0,
                          last_of_run: !item_last_ff};
         end
         ST_FINAL: begin
            push      = push_ready;
            push_data = '{x: item_x_ff, y: item_y_ff, keep: 1'b1, edge_end: 1'b1,
                          last_of_run: 1'b1};
         end
         default: begin
            sq_start = 1'b0;
         end
      endcase
   end

   // chain state and datapath
   always_comb begin
      item_x_in     = item_x_ff;
      item_y_in     = item_y_ff;
      item_first_in = item_first_ff;
      item_last_in  = item_last_ff;
      anchor_x_in   = anchor_x_ff;
      anchor_y_in   = anchor_y_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      path_in       = path_ff;
      seg_in        = seg_ff;
      chord_in      = chord_ff;
      sum_in        = sum_ff;
      keep_in       = keep_ff;
      held_valid_in = held_valid_ff;
      held_start_in = held_start_ff;
      thr_in        = csr_valid ? csr_deviation_threshold : thr_ff;
      path_wide     = {1'b0, path_ff} + {1'b0, seg_ff};
      diff          = (sum_ff > chord_ff) ? (sum_ff - chord_ff) : (chord_ff - sum_ff);

      if (accept) begin
         item_x_in     = req_point_x;
         item_y_in     = req_point_y;
         item_first_in = req_first_of_edge;
         item_last_in  = req_last_of_edge;
      end

      case (state_ff) inside
         ST_DISPATCH, ST_CLOSE: begin
            if ((state_ff == ST_DISPATCH && start_branch && !held_valid_ff) ||
                (state_ff == ST_CLOSE && push_ready)) begin
               anchor_x_in   = item_x_ff;
               anchor_y_in   = item_y_ff;
               held_x_in     = item_x_ff;
               held_y_in     = item_y_ff;
               path_in       = '0;
               held_valid_in = 1'b1;
               held_start_in = 1'b1;
            end
         end
         ST_SEG_ROOT: begin
            if (root_done) seg_in = root_len;
         end
         ST_CHORD_ROOT: begin
            if (root_done) chord_in = root_len;
         end
         ST_SUM: begin
            sum_in = path_wide[LEN_W] ? {LEN_W{1'b1}} : path_wide[LEN_W-1:0];
         end
         ST_TEST: begin
            if (diff > LEN_W'(thr_ff)) begin
               keep_in     = 1'b1;
               anchor_x_in = held_x_ff;
               anchor_y_in = held_y_ff;
               path_in     = seg_ff;
            end else begin
               keep_in = held_start_ff;
               path_in = sum_ff;
            end
         end
         ST_REPORT: begin
            if (push_ready) begin
               held_x_in     = item_x_ff;
               held_y_in     = item_y_ff;
               held_start_in = 1'b0;
            end
         end
         ST_FINAL: begin
            if (push_ready) begin
               held_valid_in = 1'b0;
               held_start_in = 1'b0;
               path_in       = '0;
            end
         end
         default: begin
            keep_in = keep_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_x_ff     <= item_x_in;
      item_y_ff     <= item_y_in;
      item_first_ff <= item_first_in;
      item_last_ff  <= item_last_in;
      anchor_x_ff   <= anchor_x_in;
      anchor_y_ff   <= anchor_y_in;
      held_x_ff     <= held_x_in;
      held_y_ff     <= held_y_in;
      seg_ff        <= seg_in;
      chord_ff      <= chord_in;
      sum_ff        <= sum_in;
      keep_ff       <= keep_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         path_ff       <= '0;
         held_valid_ff <= 1'b0;
         held_start_ff <= 1'b0;
         thr_ff        <= THR_RESET;
      end else begin
         state_ff      <= state_in;
         path_ff       <= path_in;
         held_valid_ff <= held_valid_in;
         held_start_ff <= held_start_in;
         thr_ff        <= thr_in;
      end
   end

   epsimp_sqsum u_sqsum (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .a_x   (sq_a_x),
      .a_y   (sq_a_y),
      .b_x   (item_x_ff),
      .b_y   (item_y_ff),
      .done  (sq_done),
      .sum   (sq_sum)
   );

   epsimp_root #(
      .FRAC_BITS (FRAC_BITS)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_done),
      .radicand (sq_sum),
      .done     (root_done),
      .len      (root_len)
   );

   epsimp_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (rsp_valid),
      .pop_stall  (rsp_stall),
      .pop_data   (pop_data)
   );

   assign rsp_out_x       = pop_data.x;
   assign rsp_out_y       = pop_data.y;
   assign rsp_keep        = pop_data.keep;
   assign rsp_edge_end    = pop_data.edge_end;
   assign rsp_last_of_run = pop_data.last_of_run;

   assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == ST_SEG_SQ || state_ff == ST_CHORD_SQ))
      else $error("squaring finished outside a squaring phase");

   assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == ST_SEG_ROOT || state_ff == ST_CHORD_ROOT))
      else $error("root finished outside a root phase");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DISPATCH))
      else $error("accepted beat not dispatched");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT && push_ready) |=>
         (held_x_ff == $past(item_x_ff) && !held_start_ff))
      else $error("held point not advanced after report");

endmodule
